>>> design/sfd_pkg.sv
// ----------------------------------------------------------------------------
// sfd_pkg
// Shared widths, register indexes and types for the SDF fitting
// displacement pipeline.
// ----------------------------------------------------------------------------
package sfd_pkg;

  // Default number of fraction bits of the fixed-point format
  localparam int FRAC_BITS_DEF = 16;

  // Field and product widths
  localparam int DATA_W  = 32;
  localparam int BOUND_W = 31;
  localparam int PROD_W  = 64;
  localparam int IN_W    = 7 * DATA_W;
  localparam int OUT_W   = 3 * DATA_W;
  localparam int POS_W   = 3 * DATA_W;

  // Low slice of the attraction term for the split multiply
  localparam int LO_W = 24;

  // Saturation limits of a result field
  localparam logic [DATA_W-1:0] SAT_MAX = 32'h7FFF_FFFF;
  localparam logic [DATA_W-1:0] SAT_MIN = 32'h8000_0000;

  // Configuration register indexes
  localparam int CFG_IDX_W = 3;
  localparam logic [CFG_IDX_W-1:0] REG_TRANS_X  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_TRANS_Y  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_TRANS_Z  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_TRANS_LEN = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_NEAR     = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_FAR      = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_EXT_BAND = 3'd6;

  // Configuration as seen by the datapath
  typedef struct packed {
    logic signed [DATA_W-1:0] trans_x;
    logic signed [DATA_W-1:0] trans_y;
    logic signed [DATA_W-1:0] trans_z;
    logic [BOUND_W-1:0]       tlen;
    logic [BOUND_W-1:0]       near_edge;
    logic [BOUND_W-1:0]       far_edge;
    logic [BOUND_W-1:0]       band;
  } cfg_t;

  // Weight selection: fixed weight (0 or one) or taken from the quotient
  typedef struct packed {
    logic fixed;
    logic one;
  } wmode_t;

endpackage

>>> design/sdf_fitting_displacement.sv
// ----------------------------------------------------------------------------
// sdf_fitting_displacement
// Stages from input transfer to result:
// 4 front stages, one divider stage per quotient bit, 7 blend stages.
// Throughput: one item per cycle; a stall holds only the stages behind it.
// Reset clears all valid bits and the configuration registers to zero.
// ----------------------------------------------------------------------------
module sdf_fitting_displacement #(
  parameter int FRAC_BITS = sfd_pkg::FRAC_BITS_DEF
) (
  input  logic                            clk,
  input  logic                            rst_n,
  // Configuration write port
  input  logic                            cfg_we,
  input  logic [sfd_pkg::CFG_IDX_W-1:0]   cfg_idx,
  input  logic [sfd_pkg::DATA_W-1:0]      cfg_wdata,
  // Input stream
  input  logic                            in_tvalid,
  output logic                            in_tready,
  // pos_x, pos_y, pos_z, distance, grad_x, grad_y, grad_z (32 bits each)
  input  logic [sfd_pkg::IN_W-1:0]        in_tdata,
  // Result stream
  output logic                            out_tvalid,
  input  logic                            out_tready,
  // new_x, new_y, new_z (32 bits each)
  output logic [sfd_pkg::OUT_W-1:0]       out_tdata
);
  import sfd_pkg::*;

  localparam int AW    = PROD_W - FRAC_BITS;
  localparam int PAY_W = POS_W + 3 * AW + $bits(wmode_t);

  cfg_t               cfg_r;
  cfg_t               cfg_use;
  logic [BOUND_W-1:0] near_r;
  logic [BOUND_W-1:0] far_r;

  logic               front_vld;
  logic               div_rdy;
  logic [POS_W-1:0]   front_pos;
  logic [3*AW-1:0]    front_attr;
  wmode_t             front_mode;
  logic [BOUND_W-1:0] front_rem;
  logic [BOUND_W-1:0] front_den;

  logic                 div_vld;
  logic                 blend_rdy;
  logic [FRAC_BITS-1:0] div_quo;
  logic [PAY_W-1:0]     div_pay;
  wmode_t               div_mode;

  // Register writes; unknown indexes are dropped
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= '0;
    end else if (cfg_we) begin
      case (cfg_idx)
        REG_TRANS_X:   cfg_r.trans_x   <= cfg_wdata;
        REG_TRANS_Y:   cfg_r.trans_y   <= cfg_wdata;
        REG_TRANS_Z:   cfg_r.trans_z   <= cfg_wdata;
        REG_TRANS_LEN: cfg_r.tlen      <= cfg_wdata[BOUND_W-1:0];
        REG_NEAR:      cfg_r.near_edge <= cfg_wdata[BOUND_W-1:0];
        REG_FAR:       cfg_r.far_edge  <= cfg_wdata[BOUND_W-1:0];
        REG_EXT_BAND:  cfg_r.band      <= cfg_wdata[BOUND_W-1:0];
        default: ;
      endcase
    end
  end

  // Clamp the window edges to the band once, ahead of the datapath
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      near_r <= '0;
      far_r  <= '0;
    end else begin
      near_r <= (cfg_r.near_edge < cfg_r.band) ? cfg_r.near_edge : cfg_r.band;
      far_r  <= (cfg_r.far_edge < cfg_r.band) ? cfg_r.far_edge : cfg_r.band;
    end
  end

  always_comb begin
    cfg_use           = cfg_r;
    cfg_use.near_edge = near_r;
    cfg_use.far_edge  = far_r;
  end

  sfd_front #(
    .FRAC_BITS (FRAC_BITS)
  ) u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg      (cfg_use),
    .in_vld   (in_tvalid),
    .in_rdy   (in_tready),
    .in_data  (in_tdata),
    .out_vld  (front_vld),
    .out_rdy  (div_rdy),
    .out_pos  (front_pos),
    .out_attr (front_attr),
    .out_mode (front_mode),
    .out_rem  (front_rem),
    .out_den  (front_den)
  );

  sfd_div #(
    .FRAC_BITS (FRAC_BITS),
    .PAY_W     (PAY_W)
  ) u_div (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_vld  (front_vld),
    .in_rdy  (div_rdy),
    .in_rem  (front_rem),
    .in_den  (front_den),
    .in_pay  ({front_mode, front_attr, front_pos}),
    .out_vld (div_vld),
    .out_rdy (blend_rdy),
    .out_quo (div_quo),
    .out_pay (div_pay)
  );

  assign div_mode = wmode_t'(div_pay[PAY_W-1 -: $bits(wmode_t)]);

  sfd_blend #(
    .FRAC_BITS (FRAC_BITS)
  ) u_blend (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg      (cfg_use),
    .in_vld   (div_vld),
    .in_rdy   (blend_rdy),
    .in_quo   (div_quo),
    .in_mode  (div_mode),
    .in_pos   (div_pay[POS_W-1:0]),
    .in_attr  (div_pay[POS_W +: 3*AW]),
    .out_vld  (out_tvalid),
    .out_rdy  (out_tready),
    .out_data (out_tdata)
  );

  // Input back-pressure only ever starts from a held result
  a_in_stall: assert property (@(posedge clk) disable iff (!rst_n)
    !in_tready |-> out_tvalid && !out_tready)
    else $error("input stalled without a held result");

  // A full divider has a waiting item at its end and a stalled blend stage
  a_div_stall: assert property (@(posedge clk) disable iff (!rst_n)
    !div_rdy |-> div_vld && !blend_rdy)
    else $error("divider stalled while not full");

  // Clamped edges never exceed the band once settled
  a_edges: assert property (@(posedge clk) disable iff (!rst_n)
    $past(rst_n) && !$past(cfg_we) |-> near_r <= cfg_r.band && far_r <= cfg_r.band)
    else $error("window edge above band");

endmodule

>>> design/sfd_front.sv
// ----------------------------------------------------------------------------
// sfd_front
// Input register, distance classification against the smoothstep window
// and band, attraction product and its rounding. Four register stages.
// ----------------------------------------------------------------------------
module sfd_front #(
  parameter int FRAC_BITS = sfd_pkg::FRAC_BITS_DEF
) (
  input  logic                                   clk,
  input  logic                                   rst_n,
  input  sfd_pkg::cfg_t                          cfg,
  input  logic                                   in_vld,
  output logic                                   in_rdy,
  input  logic [sfd_pkg::IN_W-1:0]               in_data,
  output logic                                   out_vld,
  input  logic                                   out_rdy,
  output logic [sfd_pkg::POS_W-1:0]              out_pos,
  output logic [3*(sfd_pkg::PROD_W-FRAC_BITS)-1:0] out_attr,
  output sfd_pkg::wmode_t                        out_mode,
  output logic [sfd_pkg::BOUND_W-1:0]            out_rem,
  output logic [sfd_pkg::BOUND_W-1:0]            out_den
);
  import sfd_pkg::*;

  localparam int NST = 4;
  localparam int AW  = PROD_W - FRAC_BITS;
  localparam logic [PROD_W-1:0] HALF64 = PROD_W'(1) << (FRAC_BITS - 1);

  // Stage control
  logic [NST-1:0] vld_r;
  logic [NST-1:0] adv;

  // Stage 0: raw input
  logic [IN_W-1:0] in_r;

  // Stage 1: classified item
  logic [POS_W-1:0]         pos1_r;
  logic signed [DATA_W-1:0] grad1_r [3];
  logic signed [DATA_W-1:0] m1_r;
  wmode_t                   mode1_r;
  logic [BOUND_W-1:0]       rem1_r;
  logic [BOUND_W-1:0]       den1_r;

  // Stage 2: products
  logic [POS_W-1:0]         pos2_r;
  logic signed [PROD_W-1:0] prod2_r [3];
  wmode_t                   mode2_r;
  logic [BOUND_W-1:0]       rem2_r;
  logic [BOUND_W-1:0]       den2_r;

  // Stage 3: rounded attraction
  logic [POS_W-1:0]         pos3_r;
  logic [AW-1:0]            attr3_r [3];
  wmode_t                   mode3_r;
  logic [BOUND_W-1:0]       rem3_r;
  logic [BOUND_W-1:0]       den3_r;

  // Classification logic
  logic signed [DATA_W-1:0] d_val;
  logic signed [DATA_W:0]   d_ext;
  logic signed [DATA_W:0]   near_ext;
  logic signed [DATA_W:0]   far_ext;
  logic signed [DATA_W:0]   tlen_ext;
  logic signed [DATA_W:0]   diff;
  logic [DATA_W:0]          abs_d;
  logic                     in_band;
  wmode_t                   mode_nxt;
  logic signed [DATA_W-1:0] m_nxt;
  logic [BOUND_W-1:0]       rem_nxt;
  logic [BOUND_W-1:0]       den_nxt;
  logic signed [PROD_W-1:0] prod_nxt [3];
  logic [PROD_W-1:0]        rsum [3];
  logic [AW-1:0]            attr_nxt [3];

  // Advance a stage when it is empty or its successor advances
  always_comb begin
    adv[NST-1] = ~vld_r[NST-1] | out_rdy;
    for (int k = NST - 2; k >= 0; k--) begin
      adv[k] = ~vld_r[k] | adv[k+1];
    end
  end

  assign in_rdy  = adv[0];
  assign out_vld = vld_r[NST-1];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else begin
      if (adv[0]) begin
        vld_r[0] <= in_vld;
      end
      for (int k = 1; k < NST; k++) begin
        if (adv[k]) begin
          vld_r[k] <= vld_r[k-1];
        end
      end
    end
  end

  // Classify distance: window position, band test and attraction scale
  always_comb begin
    d_val    = in_r[3*DATA_W +: DATA_W];
    d_ext    = {d_val[DATA_W-1], d_val};
    near_ext = $signed({2'b00, cfg.near_edge});
    far_ext  = $signed({2'b00, cfg.far_edge});
    tlen_ext = $signed({2'b00, cfg.tlen});
    diff     = d_ext - near_ext;
    abs_d    = d_val[DATA_W-1] ? (-d_ext) : d_ext;
    in_band  = abs_d < {2'b00, cfg.band};

    // Degenerate window gives a step at near; otherwise clamp at both edges
    mode_nxt = '{fixed: 1'b0, one: 1'b0};
    if (cfg.far_edge <= cfg.near_edge) begin
      mode_nxt = '{fixed: 1'b1, one: (d_ext >= near_ext)};
    end else if (d_ext <= near_ext) begin
      mode_nxt = '{fixed: 1'b1, one: 1'b0};
    end else if (d_ext >= far_ext) begin
      mode_nxt = '{fixed: 1'b1, one: 1'b1};
    end

    rem_nxt = mode_nxt.fixed ? '0 : diff[BOUND_W-1:0];
    den_nxt = cfg.far_edge - cfg.near_edge;

    // Attraction scale is min(trans_length, distance), zero outside the band
    if (!in_band) begin
      m_nxt = '0;
    end else if (tlen_ext < d_ext) begin
      m_nxt = tlen_ext[DATA_W-1:0];
    end else begin
      m_nxt = d_val;
    end

    for (int c = 0; c < 3; c++) begin
      prod_nxt[c] = grad1_r[c] * m1_r;
      rsum[c]     = HALF64 - prod2_r[c];
      attr_nxt[c] = rsum[c][PROD_W-1:FRAC_BITS];
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    if (adv[0]) begin
      in_r <= in_data;
    end
    if (adv[1]) begin
      pos1_r  <= in_r[POS_W-1:0];
      m1_r    <= m_nxt;
      mode1_r <= mode_nxt;
      rem1_r  <= rem_nxt;
      den1_r  <= den_nxt;
      for (int c = 0; c < 3; c++) begin
        grad1_r[c] <= in_r[(4+c)*DATA_W +: DATA_W];
      end
    end
    if (adv[2]) begin
      pos2_r  <= pos1_r;
      mode2_r <= mode1_r;
      rem2_r  <= rem1_r;
      den2_r  <= den1_r;
      for (int c = 0; c < 3; c++) begin
        prod2_r[c] <= prod_nxt[c];
      end
    end
    if (adv[3]) begin
      pos3_r  <= pos2_r;
      mode3_r <= mode2_r;
      rem3_r  <= rem2_r;
      den3_r  <= den2_r;
      for (int c = 0; c < 3; c++) begin
        attr3_r[c] <= attr_nxt[c];
      end
    end
  end

  assign out_pos  = pos3_r;
  assign out_attr = {attr3_r[2], attr3_r[1], attr3_r[0]};
  assign out_mode = mode3_r;
  assign out_rem  = rem3_r;
  assign out_den  = den3_r;

endmodule

>>> design/sfd_div.sv
// ----------------------------------------------------------------------------
// sfd_div
// Pipelined restoring divider: one quotient bit per stage, giving
// floor(rem * 2^FRAC_BITS / den) for rem < den, with a side payload.
// ----------------------------------------------------------------------------
module sfd_div #(
  parameter int FRAC_BITS = sfd_pkg::FRAC_BITS_DEF,
  parameter int PAY_W     = 8
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_vld,
  output logic                          in_rdy,
  input  logic [sfd_pkg::BOUND_W-1:0]   in_rem,
  input  logic [sfd_pkg::BOUND_W-1:0]   in_den,
  input  logic [PAY_W-1:0]              in_pay,
  output logic                          out_vld,
  input  logic                          out_rdy,
  output logic [FRAC_BITS-1:0]          out_quo,
  output logic [PAY_W-1:0]              out_pay
);
  import sfd_pkg::*;

  localparam int NST = FRAC_BITS;

  logic [NST-1:0] vld_r;
  logic [NST-1:0] adv;

  logic [BOUND_W-1:0]   rem_r [NST];
  logic [BOUND_W-1:0]   den_r [NST];
  logic [FRAC_BITS-1:0] quo_r [NST];
  logic [PAY_W-1:0]     pay_r [NST];

  logic [BOUND_W-1:0]   rem_nxt [NST];
  logic [FRAC_BITS-1:0] quo_nxt [NST];

  // Advance a stage when it is empty or its successor advances
  always_comb begin
    adv[NST-1] = ~vld_r[NST-1] | out_rdy;
    for (int k = NST - 2; k >= 0; k--) begin
      adv[k] = ~vld_r[k] | adv[k+1];
    end
  end

  assign in_rdy  = adv[0];
  assign out_vld = vld_r[NST-1];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else begin
      if (adv[0]) begin
        vld_r[0] <= in_vld;
      end
      for (int k = 1; k < NST; k++) begin
        if (adv[k]) begin
          vld_r[k] <= vld_r[k-1];
        end
      end
    end
  end

  // Shift the partial remainder, compare and subtract the divisor
  always_comb begin
    logic [BOUND_W-1:0]   src_rem;
    logic [BOUND_W-1:0]   src_den;
    logic [FRAC_BITS-1:0] src_quo;
    logic [BOUND_W:0]     r2;
    logic [BOUND_W:0]     dif;
    logic                 ge;
    for (int k = 0; k < NST; k++) begin
      if (k == 0) begin
        src_rem = in_rem;
        src_den = in_den;
        src_quo = '0;
      end else begin
        src_rem = rem_r[k-1];
        src_den = den_r[k-1];
        src_quo = quo_r[k-1];
      end
      r2  = {src_rem, 1'b0};
      dif = r2 - {1'b0, src_den};
      ge  = r2 >= {1'b0, src_den};
      rem_nxt[k] = ge ? dif[BOUND_W-1:0] : r2[BOUND_W-1:0];
      quo_nxt[k] = {src_quo[FRAC_BITS-2:0], ge};
    end
  end

  always_ff @(posedge clk) begin
    for (int k = 0; k < NST; k++) begin
      if (adv[k]) begin
        rem_r[k] <= rem_nxt[k];
        quo_r[k] <= quo_nxt[k];
        den_r[k] <= (k == 0) ? in_den : den_r[k-1];
        pay_r[k] <= (k == 0) ? in_pay : pay_r[k-1];
      end
    end
  end

  assign out_quo = quo_r[NST-1];
  assign out_pay = pay_r[NST-1];

endmodule

>>> design/sfd_blend.sv
// ----------------------------------------------------------------------------
// sfd_blend
// Smoothstep weight from the window ratio, blend of translation and
// attraction, rounding and saturation of the displaced position.
// ----------------------------------------------------------------------------
module sfd_blend #(
  parameter int FRAC_BITS = sfd_pkg::FRAC_BITS_DEF
) (
  input  logic                                     clk,
  input  logic                                     rst_n,
  input  sfd_pkg::cfg_t                            cfg,
  input  logic                                     in_vld,
  output logic                                     in_rdy,
  input  logic [FRAC_BITS-1:0]                     in_quo,
  input  sfd_pkg::wmode_t                          in_mode,
  input  logic [sfd_pkg::POS_W-1:0]                in_pos,
  input  logic [3*(sfd_pkg::PROD_W-FRAC_BITS)-1:0] in_attr,
  output logic                                     out_vld,
  input  logic                                     out_rdy,
  output logic [sfd_pkg::OUT_W-1:0]                out_data
);
  import sfd_pkg::*;

  localparam int NST = 7;
  localparam int AW  = PROD_W - FRAC_BITS;
  localparam int TW  = FRAC_BITS + 1;
  localparam int TTW = 2 * TW;
  localparam int GW  = FRAC_BITS + 2;
  localparam int PRW = TW + GW;
  localparam int HW  = AW - LO_W;
  localparam int PHW = HW + TW + 1;
  localparam int PLW = LO_W + TW;
  localparam int SW  = AW + 1;

  localparam logic [TW-1:0]     ONE_T   = TW'(1) << FRAC_BITS;
  localparam logic [TTW-1:0]    HALF_TT = TTW'(1) << (FRAC_BITS - 1);
  localparam logic [GW-1:0]     ONE3_G  = GW'(3) << FRAC_BITS;
  localparam logic [PRW-1:0]    HALF_PR = PRW'(1) << (FRAC_BITS - 1);
  localparam logic [PRW-1:0]    ONE_PR  = PRW'(1) << FRAC_BITS;
  localparam logic [PROD_W-1:0] HALF64  = PROD_W'(1) << (FRAC_BITS - 1);

  logic [NST-1:0] vld_r;
  logic [NST-1:0] adv;

  // Carried payload
  logic [POS_W-1:0] pos_r  [NST-1];
  logic [3*AW-1:0]  attr_r [4];

  // Weight path
  logic [TW-1:0]  t_r;
  logic [TTW-1:0] tt_r;
  logic [TW-1:0]  t2_r;
  logic [GW-1:0]  g_r;
  logic [PRW-1:0] pr_r;
  logic [TW-1:0]  s_r;
  logic [TW-1:0]  w_r;

  // Blend path
  logic signed [PROD_W-1:0] trs_r [3];
  logic [PLW-1:0]           plo_r [3];
  logic signed [PHW-1:0]    phi_r [3];
  logic [AW-1:0]            dlt_r [3];
  logic [DATA_W-1:0]        out_r [3];

  logic [TW-1:0]            t_nxt;
  logic [TTW-1:0]           tt_nxt;
  logic [TTW-1:0]           tt_sum;
  logic [TW-1:0]            t2_nxt;
  logic [GW-1:0]            g_nxt;
  logic [PRW-1:0]           pr_nxt;
  logic [PRW-1:0]           pr_sum;
  logic [PRW-1:0]           rs;
  logic [TW-1:0]            s_nxt;
  logic [TW-1:0]            w_nxt;
  logic signed [DATA_W-1:0] trans [3];
  logic signed [PROD_W-1:0] trs_nxt [3];
  logic [PLW-1:0]           plo_nxt [3];
  logic signed [PHW-1:0]    phi_nxt [3];
  logic [AW-1:0]            dlt_nxt [3];
  logic [DATA_W-1:0]        out_nxt [3];

  // Advance a stage when it is empty or its successor advances
  always_comb begin
    adv[NST-1] = ~vld_r[NST-1] | out_rdy;
    for (int k = NST - 2; k >= 0; k--) begin
      adv[k] = ~vld_r[k] | adv[k+1];
    end
  end

  assign in_rdy  = adv[0];
  assign out_vld = vld_r[NST-1];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else begin
      if (adv[0]) begin
        vld_r[0] <= in_vld;
      end
      for (int k = 1; k < NST; k++) begin
        if (adv[k]) begin
          vld_r[k] <= vld_r[k-1];
        end
      end
    end
  end

  // Smoothstep: t2 = rnd(t*t), s = rnd(t2*(3 - 2t)), clamp to one
  always_comb begin
    t_nxt  = in_mode.fixed ? (in_mode.one ? ONE_T : '0) : {1'b0, in_quo};
    tt_nxt = {{TW{1'b0}}, t_nxt} * {{TW{1'b0}}, t_nxt};
    tt_sum = tt_r + HALF_TT;
    t2_nxt = TW'(tt_sum >> FRAC_BITS);
    g_nxt  = ONE3_G - {t_r, 1'b0};
    pr_nxt = {{GW{1'b0}}, t2_r} * {{TW{1'b0}}, g_r};
    pr_sum = pr_r + HALF_PR;
    rs     = pr_sum >> FRAC_BITS;
    s_nxt  = (rs > ONE_PR) ? ONE_T : rs[TW-1:0];
    w_nxt  = ONE_T - s_nxt;
  end

  // Blend products, rounded sum and saturated result per axis
  always_comb begin
    logic [AW-1:0]     a_c;
    logic [PROD_W-1:0] hi64;
    logic [PROD_W-1:0] lo64;
    logic [PROD_W-1:0] sum;
    logic [SW-1:0]     ps;
    logic [SW-32:0]    top;
    trans[0] = cfg.trans_x;
    trans[1] = cfg.trans_y;
    trans[2] = cfg.trans_z;
    for (int c = 0; c < 3; c++) begin
      // Split the attraction term so each multiply stays narrow
      a_c        = attr_r[3][c*AW +: AW];
      trs_nxt[c] = trans[c] * $signed({1'b0, s_r});
      plo_nxt[c] = {{TW{1'b0}}, a_c[LO_W-1:0]} * {{LO_W{1'b0}}, w_r};
      phi_nxt[c] = $signed(a_c[AW-1:LO_W]) * $signed({1'b0, w_r});

      hi64 = {{(PROD_W-PHW){phi_r[c][PHW-1]}}, phi_r[c]} << LO_W;
      lo64 = {{(PROD_W-PLW){1'b0}}, plo_r[c]};
      sum  = trs_r[c] + hi64 + lo64 + HALF64;
      dlt_nxt[c] = sum[PROD_W-1:FRAC_BITS];

      // Saturate pos + delta to the 32-bit range
      ps  = {{(SW-DATA_W){pos_r[5][c*DATA_W+DATA_W-1]}}, pos_r[5][c*DATA_W +: DATA_W]}
          + {dlt_r[c][AW-1], dlt_r[c]};
      top = ps[SW-1:DATA_W-1];
      if (top == '0 || top == '1) begin
        out_nxt[c] = ps[DATA_W-1:0];
      end else begin
        out_nxt[c] = ps[SW-1] ? SAT_MIN : SAT_MAX;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv[0]) begin
      t_r       <= t_nxt;
      tt_r      <= tt_nxt;
      pos_r[0]  <= in_pos;
      attr_r[0] <= in_attr;
    end
    if (adv[1]) begin
      t2_r      <= t2_nxt;
      g_r       <= g_nxt;
      pos_r[1]  <= pos_r[0];
      attr_r[1] <= attr_r[0];
    end
    if (adv[2]) begin
      pr_r      <= pr_nxt;
      pos_r[2]  <= pos_r[1];
      attr_r[2] <= attr_r[1];
    end
    if (adv[3]) begin
      s_r       <= s_nxt;
      w_r       <= w_nxt;
      pos_r[3]  <= pos_r[2];
      attr_r[3] <= attr_r[2];
    end
    if (adv[4]) begin
      pos_r[4] <= pos_r[3];
      for (int c = 0; c < 3; c++) begin
        trs_r[c] <= trs_nxt[c];
        plo_r[c] <= plo_nxt[c];
        phi_r[c] <= phi_nxt[c];
      end
    end
    if (adv[5]) begin
      pos_r[5] <= pos_r[4];
      for (int c = 0; c < 3; c++) begin
        dlt_r[c] <= dlt_nxt[c];
      end
    end
    if (adv[6]) begin
      for (int c = 0; c < 3; c++) begin
        out_r[c] <= out_nxt[c];
      end
    end
  end

  assign out_data = {out_r[2], out_r[1], out_r[0]};

endmodule
